// ===== hw/rtl/tds_pkg.sv =====
// Shared types and constants for the timer divider solver.
`timescale 1ns / 1ps

package tds_pkg;

    localparam int DATA_W = 24;
    localparam int DIV_CNT_W = 5;

    localparam logic [23:0] CLOCK_HZ_RESET = 24'd8000000;

    localparam logic [1:0] CFG_CLOCK_HZ = 2'd0;
    localparam logic [1:0] CFG_PWM_MODE = 2'd1;
    localparam logic [1:0] CFG_SIX_BIT_PWM = 2'd2;

    localparam logic [1:0] DIV_SEL_RATIO = 2'd0;
    localparam logic [1:0] DIV_SEL_SEARCH = 2'd1;

    localparam logic [23:0] PERIOD_LIMIT = 24'd8192;
    localparam logic [23:0] PWM_LIMIT = 24'd32;
    localparam logic [1:0] CODE_MAX = 2'd3;
    localparam logic [8:0] DIVISOR_FIRST = 9'd256;
    localparam logic [8:0] DIVISOR_LAST = 9'd2;
    localparam logic [7:0] DUTY_MAX = 8'd100;
    localparam logic [7:0] DUTY_DEFAULT = 8'd50;
    localparam logic [23:0] PERCENT_DIV = 24'd100;

    // Reciprocal of 100 scaled by 2^19; exact for products up to 43690.
    localparam logic [12:0] PERCENT_RECIP = 13'd5243;
    localparam int PERCENT_SHIFT = 19;

    typedef struct packed {
        logic       load_item;
        logic       div_start;
        logic [1:0] div_sel;
        logic       take_ratio;
        logic       presc_step;
        logic       search_take;
        logic       out_load;
    } tds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic presc_more;
        logic search_last;
        logic pwm_mode;
    } tds_status_t;

endpackage

// ===== hw/rtl/tds_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tds_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tds_pkg::DATA_W-1:0]  dividend,
    input  logic [tds_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [tds_pkg::DATA_W-1:0]  quotient,
    output logic [tds_pkg::DATA_W-1:0]  remainder
);

    logic [tds_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [tds_pkg::DATA_W-1:0]    quo_reg, quo_next;
    logic [tds_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [tds_pkg::DATA_W-1:0]    dsr_reg, dsr_next;
    logic [tds_pkg::DATA_W:0]      partial;
    logic [tds_pkg::DATA_W:0]      diff;
    logic                          ge;

    // A zero divisor gives an all-ones quotient, since every compare passes.
    assign partial = {rem_reg, quo_reg[tds_pkg::DATA_W-1]};
    assign diff = partial - {1'b0, dsr_reg};
    assign ge = (partial >= {1'b0, dsr_reg});

    always_comb
    begin
        cnt_next = cnt_reg;
        done_next = 1'b0;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = tds_pkg::DIV_CNT_W'(tds_pkg::DATA_W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[tds_pkg::DATA_W-2:0], ge};
            rem_next = ge ? diff[tds_pkg::DATA_W-1:0] : partial[tds_pkg::DATA_W-1:0];
            done_next = (cnt_reg == tds_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/tds_datapath.sv =====
// Datapath: configuration, item registers, ratio, divisor search and result.
`timescale 1ns / 1ps

module tds_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [23:0]           cfg_data,
    input  logic [23:0]           target_hz,
    input  logic [7:0]            duty_percent,
    input  tds_pkg::tds_cmd_t     cmd,
    output tds_pkg::tds_status_t  status,
    output logic [1:0]            prescale_code,
    output logic [7:0]            scalar,
    output logic [7:0]            bound
);

    logic [23:0] clock_hz_reg, clock_hz_next;
    logic        pwm_mode_reg, pwm_mode_next;
    logic        six_bit_reg, six_bit_next;
    logic [23:0] target_reg;
    logic [7:0]  duty_reg;
    logic [23:0] ratio_reg;
    logic [1:0]  code_reg;
    logic [8:0]  d_reg;
    logic [8:0]  best_rem_reg;
    logic [7:0]  best_bound_reg;
    logic [7:0]  best_scalar_reg;
    logic [1:0]  out_code_reg;
    logic [7:0]  out_scalar_reg;
    logic [7:0]  out_bound_reg;

    logic [23:0] div_dividend;
    logic [23:0] div_divisor;
    logic        div_done;
    logic [23:0] div_quo;
    logic [23:0] div_rem;
    logic [15:0] duty_product;
    logic [27:0] duty_scaled;
    logic [8:0]  duty_quot;
    logic [7:0]  pwm_bound;
    logic [23:0] ratio_limit;

    always_comb
    begin
        clock_hz_next = clock_hz_reg;
        pwm_mode_next = pwm_mode_reg;
        six_bit_next = six_bit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tds_pkg::CFG_CLOCK_HZ:    clock_hz_next = cfg_data;
                tds_pkg::CFG_PWM_MODE:    pwm_mode_next = cfg_data[0];
                tds_pkg::CFG_SIX_BIT_PWM: six_bit_next = cfg_data[0];
                default:                  clock_hz_next = clock_hz_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= tds_pkg::CLOCK_HZ_RESET;
            pwm_mode_reg <= 1'b0;
            six_bit_reg <= 1'b0;
        end
        else
        begin
            clock_hz_reg <= clock_hz_next;
            pwm_mode_reg <= pwm_mode_next;
            six_bit_reg <= six_bit_next;
        end
    end

    assign duty_product = six_bit_reg ? {2'b00, duty_reg, 6'b000000} : {duty_reg, 8'h00};
    assign ratio_limit = pwm_mode_reg ? tds_pkg::PWM_LIMIT : tds_pkg::PERIOD_LIMIT;

    // The duty product is at most 25600, so the scaled reciprocal gives the exact quotient.
    assign duty_scaled = 28'(duty_product) * 28'(tds_pkg::PERCENT_RECIP);
    assign duty_quot = duty_scaled[tds_pkg::PERCENT_SHIFT +: 9];
    assign pwm_bound = 8'(duty_quot - 9'd1);

    always_comb
    begin
        case (cmd.div_sel)
            tds_pkg::DIV_SEL_RATIO:
            begin
                if (!pwm_mode_reg)
                    div_dividend = clock_hz_reg;
                else if (six_bit_reg)
                    div_dividend = {6'b0, clock_hz_reg[23:6]};
                else
                    div_dividend = {8'b0, clock_hz_reg[23:8]};
                div_divisor = target_reg;
            end
            tds_pkg::DIV_SEL_SEARCH:
            begin
                div_dividend = ratio_reg;
                div_divisor = {15'b0, d_reg};
            end
            default:
            begin
                div_dividend = ratio_reg;
                div_divisor = target_reg;
            end
        endcase
    end

    tds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            target_reg <= (target_hz == 24'd0) ? {4'b0, clock_hz_reg[23:4]} : target_hz;
            duty_reg <= (duty_percent == 8'd0 || duty_percent > tds_pkg::DUTY_MAX)
                        ? tds_pkg::DUTY_DEFAULT : duty_percent;
        end
        if (cmd.take_ratio)
        begin
            ratio_reg <= pwm_mode_reg ? div_quo : {1'b0, div_quo[23:1]};
            code_reg <= 2'd0;
            d_reg <= tds_pkg::DIVISOR_FIRST;
            best_rem_reg <= '1;
        end
        else if (cmd.presc_step)
        begin
            ratio_reg <= {2'b00, ratio_reg[23:2]};
            code_reg <= code_reg + 2'd1;
        end
        if (cmd.search_take)
        begin
            // Scanning downward, the first divisor with the smallest remainder wins.
            if (div_rem[8:0] < best_rem_reg)
            begin
                best_rem_reg <= div_rem[8:0];
                best_bound_reg <= 8'(d_reg - 9'd1);
                best_scalar_reg <= div_quo[7:0] - 8'd1;
            end
            d_reg <= d_reg - 9'd1;
        end
        if (cmd.out_load)
        begin
            out_code_reg <= code_reg;
            out_scalar_reg <= pwm_mode_reg ? (ratio_reg[7:0] - 8'd1) : best_scalar_reg;
            out_bound_reg <= pwm_mode_reg ? pwm_bound : best_bound_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.presc_more = (ratio_reg > ratio_limit) && (code_reg != tds_pkg::CODE_MAX);
    assign status.search_last = (div_rem == 24'd0) || (d_reg == tds_pkg::DIVISOR_LAST);
    assign status.pwm_mode = pwm_mode_reg;

    assign prescale_code = out_code_reg;
    assign scalar = out_scalar_reg;
    assign bound = out_bound_reg;

endmodule

// ===== hw/rtl/tds_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps

module tds_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  tds_pkg::tds_status_t  status,
    output tds_pkg::tds_cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RATIO_GO = 4'd1;
    localparam logic [3:0] ST_RATIO_WAIT = 4'd2;
    localparam logic [3:0] ST_PRESC = 4'd3;
    localparam logic [3:0] ST_SRCH_GO = 4'd4;
    localparam logic [3:0] ST_SRCH_WAIT = 4'd5;
    localparam logic [3:0] ST_OUT = 4'd6;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // The output register can be refilled in the cycle its item is taken.
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.div_sel = tds_pkg::DIV_SEL_RATIO;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_RATIO_GO;
                end
            end
            ST_RATIO_GO:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_ratio = 1'b1;
                    state_next = ST_PRESC;
                end
            end
            ST_PRESC:
            begin
                if (status.presc_more)
                    cmd.presc_step = 1'b1;
                else if (status.pwm_mode)
                    state_next = ST_OUT;
                else
                    state_next = ST_SRCH_GO;
            end
            ST_SRCH_GO:
            begin
                cmd.div_sel = tds_pkg::DIV_SEL_SEARCH;
                cmd.div_start = 1'b1;
                state_next = ST_SRCH_WAIT;
            end
            ST_SRCH_WAIT:
            begin
                cmd.div_sel = tds_pkg::DIV_SEL_SEARCH;
                if (status.div_done)
                begin
                    cmd.search_take = 1'b1;
                    state_next = status.search_last ? ST_OUT : ST_SRCH_GO;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/timer_divider_solver_top.sv =====
// Top level of the timer divider solver: controller, datapath and ports.
// Period mode adds one divider run per divisor tried, from 256 down to 2; PWM mode
// skips this divisor search.
// The ratio and each divisor trial run through one shared 24-bit bit-serial divider.
// One item is in work at a time; the next can be accepted in the cycle after the result loads.
// Reset loads clock_hz 8000000, period mode, 8-bit PWM depth, and an empty output.
`timescale 1ns / 1ps

module timer_divider_solver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] target_hz,
    input  logic [7:0]  duty_percent,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  prescale_code,
    output logic [7:0]  scalar,
    output logic [7:0]  bound
);

    tds_pkg::tds_cmd_t    cmd;
    tds_pkg::tds_status_t status;

    tds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tds_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target_hz     (target_hz),
        .duty_percent  (duty_percent),
        .cmd           (cmd),
        .status        (status),
        .prescale_code (prescale_code),
        .scalar        (scalar),
        .bound         (bound)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the timer divider solver top level.
`timescale 1ns / 1ps

module tb;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int RANDOM_PER_PHASE = 25;

    typedef struct {
        logic [23:0] target;
        logic [7:0]  duty;
    } freq_request_t;

    typedef struct {
        logic [1:0] code;
        logic [7:0] scalar;
        logic [7:0] bound;
    } timer_setting_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = tds_pkg::CFG_CLOCK_HZ;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [23:0] target_hz = '0;
    logic [7:0]  duty_percent = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  prescale_code;
    logic [7:0]  scalar;
    logic [7:0]  bound;

    // Shadow copy of the configuration registers.
    logic [23:0] clock_hz_shadow = tds_pkg::CLOCK_HZ_RESET;
    logic        pwm_shadow = 1'b0;
    logic        six_bit_shadow = 1'b0;

    freq_request_t  request_q[$];
    timer_setting_t setting_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    timer_divider_solver_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .target_hz(target_hz),
        .duty_percent(duty_percent),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .prescale_code(prescale_code),
        .scalar(scalar),
        .bound(bound)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [23:0] divide_or_ones(logic [23:0] num, logic [23:0] den);
        if (den == '0)
            return 24'hFFFFFF;
        return num / den;
    endfunction

    // Computes the timer settings for one request under the shadow configuration.
    function automatic timer_setting_t solve_timer(logic [23:0] target_in, logic [7:0] duty_in);
        timer_setting_t res;
        logic [23:0] tgt;
        logic [23:0] ratio;
        logic [31:0] depth;
        logic [31:0] duty;
        logic [31:0] quo;
        logic [31:0] rem;
        logic [31:0] duty_frac;
        logic [1:0]  code;
        int          tol;
        int          d;
        bit          found;
        tgt = (target_in == '0) ? (clock_hz_shadow >> 4) : target_in;
        code = 2'd0;
        quo = 0;
        if (pwm_shadow)
        begin
            depth = six_bit_shadow ? 32'd64 : 32'd256;
            ratio = divide_or_ones(clock_hz_shadow / depth[23:0], tgt);
            while (ratio > tds_pkg::PWM_LIMIT && code < tds_pkg::CODE_MAX)
            begin
                ratio = ratio >> 2;
                code = code + 2'd1;
            end
            duty = {24'd0, duty_in};
            if (duty == 0 || duty > tds_pkg::DUTY_MAX)
                duty = tds_pkg::DUTY_DEFAULT;
            duty_frac = (duty * depth) / tds_pkg::PERCENT_DIV;
            res.scalar = ratio[7:0] - 8'd1;
            res.bound = duty_frac[7:0] - 8'd1;
        end
        else
        begin
            ratio = divide_or_ones(clock_hz_shadow, tgt) >> 1;
            while (ratio > tds_pkg::PERIOD_LIMIT && code < tds_pkg::CODE_MAX)
            begin
                ratio = ratio >> 2;
                code = code + 2'd1;
            end
            // Widen the allowed remainder step by step; the largest divisor wins.
            found = 1'b0;
            d = 2;
            for (tol = 0; tol <= 32 && !found; tol++)
            begin
                for (d = 256; d >= 2; d--)
                begin
                    quo = ratio / d;
                    rem = ratio % d;
                    if (rem <= tol)
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                if (d < 2)
                    d = 2;
            end
            res.bound = 8'(d - 1);
            res.scalar = quo[7:0] - 8'd1;
        end
        res.code = code;
        return res;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            tds_pkg::CFG_CLOCK_HZ: clock_hz_shadow = value;
            tds_pkg::CFG_PWM_MODE: pwm_shadow = value[0];
            tds_pkg::CFG_SIX_BIT_PWM: six_bit_shadow = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || setting_q.size() != 0);
    endtask

    task automatic queue_request(logic [23:0] target, logic [7:0] duty);
        freq_request_t req;
        req.target = target;
        req.duty = duty;
        request_q.push_back(req);
    endtask

    function automatic logic [23:0] pick_target();
        case ($urandom_range(0, 7))
            0, 1: return 24'($urandom_range(0, 24'hFFFFFF));
            2: return 24'($urandom_range(0, 255));
            3, 4: return 24'($urandom_range(0, 65535));
            5: return 24'd0;
            default: return 24'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [7:0] pick_duty();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'($urandom_range(99, 102));
            2: return 8'($urandom_range(0, 100));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [23:0] pick_clock();
        case ($urandom_range(0, 4))
            0: return 24'd16;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1000000, 20000000 > 24'hFFFFFF ? 24'hFFFFFF : 20000000));
            default: return 24'($urandom_range(16, 24'hFFFFFF));
        endcase
    endfunction

    // Driver: launches queued requests and records the expected settings on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin : drive_blk
            freq_request_t req;
            if (in_valid && !in_stall)
                setting_q.push_back(solve_timer(target_hz, duty_percent));
            if (!in_valid || !in_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req = request_q.pop_front();
                    in_valid <= 1'b1;
                    target_hz <= req.target;
                    duty_percent <= req.duty;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin : check_blk
            timer_setting_t want;
            if (out_valid && !out_stall)
            begin
                if (setting_q.size() == 0)
                begin
                    $error("result with no request pending: code %0d scalar %0d bound %0d",
                           prescale_code, scalar, bound);
                    fail_count++;
                end
                else
                begin
                    want = setting_q.pop_front();
                    if (prescale_code !== want.code)
                    begin
                        $error("prescale_code: expected %0d, got %0d", want.code, prescale_code);
                        fail_count++;
                    end
                    if (scalar !== want.scalar)
                    begin
                        $error("scalar: expected %0d, got %0d", want.scalar, scalar);
                        fail_count++;
                    end
                    if (bound !== want.bound)
                    begin
                        $error("bound: expected %0d, got %0d", want.bound, bound);
                        fail_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timer_divider_solver_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : sequence_blk
        int phase;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Period mode at the reset clock: default target, prescaler limit, zero ratio.
        queue_request(24'd0, 8'd0);
        queue_request(24'd1, 8'd255);
        queue_request(24'd1000, 8'd50);
        queue_request(24'hFFFFFF, 8'd128);
        queue_request(24'd7919, 8'd1);
        wait_drained();

        write_reg(tds_pkg::CFG_CLOCK_HZ, 24'hFFFFFF);
        queue_request(24'd1, 8'd0);
        queue_request(24'd3, 8'd100);
        wait_drained();

        write_reg(tds_pkg::CFG_CLOCK_HZ, 24'd16);
        queue_request(24'd0, 8'd0);
        queue_request(24'd17, 8'd101);
        wait_drained();

        // PWM mode with 8-bit depth: duty defaults and a zero ratio.
        write_reg(tds_pkg::CFG_CLOCK_HZ, tds_pkg::CLOCK_HZ_RESET);
        write_reg(tds_pkg::CFG_PWM_MODE, 24'd1);
        write_reg(tds_pkg::CFG_SIX_BIT_PWM, 24'd0);
        queue_request(24'd0, 8'd0);
        queue_request(24'd1, 8'd1);
        queue_request(24'd100, 8'd100);
        queue_request(24'd2000, 8'd101);
        queue_request(24'd31, 8'd255);
        queue_request(24'hFFFFFF, 8'd50);
        wait_drained();

        // 6-bit depth, where a small duty wraps the bound.
        write_reg(tds_pkg::CFG_SIX_BIT_PWM, 24'd1);
        queue_request(24'd1, 8'd2);
        queue_request(24'd1, 8'd1);
        queue_request(24'd500, 8'd0);
        queue_request(24'd0, 8'd99);
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 83; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 83; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_reg(tds_pkg::CFG_CLOCK_HZ, pick_clock());
            write_reg(tds_pkg::CFG_PWM_MODE, 24'($urandom_range(0, 1)));
            write_reg(tds_pkg::CFG_SIX_BIT_PWM, 24'($urandom_range(0, 1)));
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Halfway through, hold the sender back until everything has drained.
                if (n == RANDOM_PER_PHASE / 2)
                    wait_drained();
                queue_request(pick_target(), pick_duty());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && setting_q.size() == 0)
            $display("timer_divider_solver_top regression: pass");
        else
            $display("timer_divider_solver_top regression: fail");
        $finish;
    end

endmodule
